// File: sv/aasd_pkg.sv
// Shared types, widths, register codes and reset values for the accelerometer
// average step detector. No dependencies; every file but aasd_ram imports it.
`default_nettype none

package aasd_pkg;

    // Field widths
    localparam int AXES     = 3;
    localparam int SAMPLE_W = 13;
    localparam int GRAV_W   = 14;
    localparam int LIMIT_W  = 16;
    localparam int MAG_W    = 16;
    localparam int AVG_W    = SAMPLE_W + 1;   // one bit wider than a sample
    localparam int DIFF_W   = GRAV_W + 1;     // average minus gravity
    localparam int ABS_W    = GRAV_W;         // |difference| stays below 2**14
    localparam int SQ_W     = 2 * ABS_W;
    localparam int TOTAL_W  = SQ_W + 2;       // sum of three squares

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // Register port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Defaults for the top-level parameters
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_ROUND_SCALE  = 2;

    // Register reset values
    localparam logic signed [GRAV_W-1:0] GRAVITY_X_RST    = 14'sd0;
    localparam logic signed [GRAV_W-1:0] GRAVITY_Y_RST    = 14'sd0;
    localparam logic signed [GRAV_W-1:0] GRAVITY_Z_RST    = 14'sd256;
    localparam logic [LIMIT_W-1:0]       STEP_THRESH_RST  = 16'd4000;
    localparam logic [LIMIT_W-1:0]       REARM_THRESH_RST = 16'd1000;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_GRAVITY_X    = 3'd0,
        REG_GRAVITY_Y    = 3'd1,
        REG_GRAVITY_Z    = 3'd2,
        REG_STEP_THRESH  = 3'd3,
        REG_REARM_THRESH = 3'd4
    } t_reg_idx;

    // Configuration handed from the register block to the detector
    typedef struct packed {
        logic signed [GRAV_W-1:0] gravity_x;
        logic signed [GRAV_W-1:0] gravity_y;
        logic signed [GRAV_W-1:0] gravity_z;
        logic [LIMIT_W-1:0]       step_thresh;
        logic [LIMIT_W-1:0]       rearm_thresh;
    } t_cfg;

    // Running sum width for a window of the given depth
    function automatic int sum_width(input int depth);
        return SAMPLE_W + $clog2(depth);
    endfunction

    // Width of scale * sum + depth, signed
    function automatic int num_width(input int depth, input int scale);
        return sum_width(depth) + $clog2(scale) + 1;
    endfunction

endpackage

`default_nettype wire

// File: sv/aasd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependency.
`default_nettype none

module aasd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/aasd_regs.sv
// APB-style configuration registers: gravity vector and the two thresholds.
// Depends on aasd_pkg for widths, register codes and reset values.
`default_nettype none

module aasd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aasd_pkg::PADDR_W-1:0] paddr,
    input  logic [aasd_pkg::PDATA_W-1:0] pwdata,
    output logic [aasd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output aasd_pkg::t_cfg               o_cfg
);

    import aasd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);

    // Write registers; unknown addresses drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_x    <= GRAVITY_X_RST;
            r_cfg.gravity_y    <= GRAVITY_Y_RST;
            r_cfg.gravity_z    <= GRAVITY_Z_RST;
            r_cfg.step_thresh  <= STEP_THRESH_RST;
            r_cfg.rearm_thresh <= REARM_THRESH_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_GRAVITY_X:    r_cfg.gravity_x    <= pwdata[GRAV_W-1:0];
                REG_GRAVITY_Y:    r_cfg.gravity_y    <= pwdata[GRAV_W-1:0];
                REG_GRAVITY_Z:    r_cfg.gravity_z    <= pwdata[GRAV_W-1:0];
                REG_STEP_THRESH:  r_cfg.step_thresh  <= pwdata[LIMIT_W-1:0];
                REG_REARM_THRESH: r_cfg.rearm_thresh <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back, gravity sign-extended
    always_comb begin
        unique case (idx)
            REG_GRAVITY_X: prdata = {{(PDATA_W-GRAV_W){r_cfg.gravity_x[GRAV_W-1]}},
                                     r_cfg.gravity_x};
            REG_GRAVITY_Y: prdata = {{(PDATA_W-GRAV_W){r_cfg.gravity_y[GRAV_W-1]}},
                                     r_cfg.gravity_y};
            REG_GRAVITY_Z: prdata = {{(PDATA_W-GRAV_W){r_cfg.gravity_z[GRAV_W-1]}},
                                     r_cfg.gravity_z};
            REG_STEP_THRESH:  prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_cfg.step_thresh};
            REG_REARM_THRESH: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_cfg.rearm_thresh};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/aasd_window.sv
// Sample ring in RAM plus per-axis running sums; emits |scale*sum + depth| and sign.
// Depends on aasd_pkg and aasd_ram.
`default_nettype none

module aasd_window #(
    parameter int WINDOW_DEPTH = aasd_pkg::DEF_WINDOW_DEPTH,
    parameter int ROUND_SCALE  = aasd_pkg::DEF_ROUND_SCALE,
    localparam int NUM_W = aasd_pkg::num_width(WINDOW_DEPTH, ROUND_SCALE)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [aasd_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic signed [aasd_pkg::SAMPLE_W-1:0] i_sample_y,
    input  logic signed [aasd_pkg::SAMPLE_W-1:0] i_sample_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [NUM_W-1:0]                    o_num_abs [aasd_pkg::AXES],
    output logic                                o_num_neg [aasd_pkg::AXES]
);

    import aasd_pkg::*;

    localparam int SUM_W  = sum_width(WINDOW_DEPTH);
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int RAM_W  = AXES * SAMPLE_W;
    localparam logic [SLOT_W-1:0]      LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic signed [NUM_W-1:0] SCALE_C  = NUM_W'(ROUND_SCALE);
    localparam logic signed [NUM_W-1:0] BIAS_C   = NUM_W'(WINDOW_DEPTH);

    // Slot pointer and first-lap flag (entries not yet written read as zero)
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_wrapped;

    // Stage 1: sample waiting for its old ring entry
    logic                       r_s1_v;
    logic [SLOT_W-1:0]          r_s1_slot;
    logic                       r_s1_live;
    logic signed [SAMPLE_W-1:0] r_s1_sample [AXES];

    // Stage A: rounding numerator, magnitude and sign
    logic             r_a_v;
    logic [NUM_W-1:0] r_abs [AXES];
    logic             r_neg [AXES];

    logic signed [SUM_W-1:0]    r_sum [AXES];
    logic signed [SUM_W-1:0]    n_sum [AXES];
    logic signed [SAMPLE_W-1:0] old_smp [AXES];
    logic signed [NUM_W-1:0]    n_num [AXES];

    logic [RAM_W-1:0] ram_rdata;
    logic [RAM_W-1:0] ram_wdata;

    logic accept;
    logic s1_ready;
    logic s1_adv;
    logic a_ready;

    // Handshake
    assign a_ready  = !r_a_v || i_ready;
    assign s1_ready = !r_s1_v || a_ready;
    assign s1_adv   = r_s1_v && a_ready;
    assign accept   = i_valid && s1_ready;
    assign o_stall  = !s1_ready;
    assign o_valid  = r_a_v;

    assign n_slot    = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign ram_wdata = {r_s1_sample[2], r_s1_sample[1], r_s1_sample[0]};

    // Update sums and form scale*sum + depth
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            old_smp[k] = r_s1_live ? $signed(ram_rdata[k*SAMPLE_W +: SAMPLE_W]) : '0;
            n_sum[k]   = r_sum[k] + SUM_W'(r_s1_sample[k]) - SUM_W'(old_smp[k]);
            n_num[k]   = NUM_W'(n_sum[k]) * SCALE_C + BIAS_C;
        end
    end

    // Ring memory, all three axes in one word
    aasd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_slot),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_wrapped <= 1'b0;
            r_s1_v    <= 1'b0;
            r_a_v     <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (accept) begin
                r_slot <= n_slot;
                if (r_slot == LAST_SLOT) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (s1_ready) begin
                r_s1_v <= i_valid;
            end
            if (a_ready) begin
                r_a_v <= r_s1_v;
            end
            if (s1_adv) begin
                r_sum <= n_sum;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample[0] <= i_sample_x;
            r_s1_sample[1] <= i_sample_y;
            r_s1_sample[2] <= i_sample_z;
            r_s1_slot      <= r_slot;
            r_s1_live      <= r_wrapped;
        end
        if (s1_adv) begin
            for (int k = 0; k < AXES; k++) begin
                r_neg[k] <= n_num[k][NUM_W-1];
                r_abs[k] <= n_num[k][NUM_W-1] ? $unsigned(-n_num[k]) : $unsigned(n_num[k]);
            end
        end
    end

    assign o_num_abs = r_abs;
    assign o_num_neg = r_neg;

endmodule

`default_nettype wire

// File: sv/aasd_scale.sv
// Divide by scale*depth through a reciprocal multiply, truncating toward zero.
// Depends on aasd_pkg.
`default_nettype none

module aasd_scale #(
    parameter int WINDOW_DEPTH = aasd_pkg::DEF_WINDOW_DEPTH,
    parameter int ROUND_SCALE  = aasd_pkg::DEF_ROUND_SCALE,
    localparam int NUM_W = aasd_pkg::num_width(WINDOW_DEPTH, ROUND_SCALE)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [NUM_W-1:0]                  i_num_abs [aasd_pkg::AXES],
    input  logic                              i_num_neg [aasd_pkg::AXES],
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [aasd_pkg::AVG_W-1:0] o_avg [aasd_pkg::AXES]
);

    import aasd_pkg::*;

    // floor(n / D) = (n * ceil(2**K / D)) >> K, exact for n < 2**NUM_W
    localparam int DIVISOR = ROUND_SCALE * WINDOW_DEPTH;
    localparam int SHIFT_K = NUM_W + $clog2(DIVISOR);
    localparam int MAGIC_W = NUM_W + 1;
    localparam int PROD_W  = NUM_W + MAGIC_W;
    localparam int Q_W     = SAMPLE_W;
    localparam logic [63:0] MAGIC_FULL =
        ((64'd1 << SHIFT_K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_FULL[MAGIC_W-1:0];

    logic              r_b_v;
    logic [PROD_W-1:0] r_prod [AXES];
    logic              r_b_neg [AXES];

    logic                    r_c_v;
    logic signed [AVG_W-1:0] r_avg [AXES];
    logic signed [AVG_W-1:0] n_avg [AXES];
    logic [Q_W-1:0]          quo [AXES];

    logic b_ready;
    logic c_ready;

    assign c_ready = !r_c_v || i_ready;
    assign b_ready = !r_b_v || c_ready;
    assign o_ready = b_ready;
    assign o_valid = r_c_v;

    // Take the quotient and restore the sign
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            quo[k]   = r_prod[k][SHIFT_K +: Q_W];
            n_avg[k] = r_b_neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (b_ready) begin
                r_b_v <= i_valid;
            end
            if (c_ready) begin
                r_c_v <= r_b_v;
            end
        end
    end

    // Multiply, then register the averages
    always_ff @(posedge i_clk) begin
        if (i_valid && b_ready) begin
            for (int k = 0; k < AXES; k++) begin
                r_prod[k]  <= PROD_W'(i_num_abs[k]) * PROD_W'(MAGIC);
                r_b_neg[k] <= i_num_neg[k];
            end
        end
        if (r_b_v && c_ready) begin
            r_avg <= n_avg;
        end
    end

    assign o_avg = r_avg;

endmodule

`default_nettype wire

// File: sv/aasd_detect.sv
// Gravity removal, squared magnitude with saturation, armed step decision, output register.
// Depends on aasd_pkg.
`default_nettype none

module aasd_detect (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  aasd_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [aasd_pkg::AVG_W-1:0]    i_avg [aasd_pkg::AXES],
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [aasd_pkg::SAMPLE_W-1:0] o_avg_x,
    output logic signed [aasd_pkg::SAMPLE_W-1:0] o_avg_y,
    output logic signed [aasd_pkg::SAMPLE_W-1:0] o_avg_z,
    output logic [aasd_pkg::MAG_W-1:0]           o_magnitude,
    output logic                                 o_step_seen
);

    import aasd_pkg::*;

    logic signed [GRAV_W-1:0] grav [AXES];
    logic signed [DIFF_W-1:0] diff [AXES];
    logic [ABS_W-1:0]         diff_abs [AXES];

    // Stage D: squares
    logic                       r_d_v;
    logic signed [SAMPLE_W-1:0] r_d_avg [AXES];
    logic [SQ_W-1:0]            r_sq [AXES];

    // Stage E: result
    logic                       r_e_v;
    logic signed [SAMPLE_W-1:0] r_out_avg [AXES];
    logic [MAG_W-1:0]           r_mag;
    logic                       r_step;
    logic                       r_armed;

    logic [TOTAL_W-1:0] total;
    logic [MAG_W-1:0]   mag;
    logic               step;
    logic               d_ready;
    logic               e_ready;
    logic               d_adv;

    assign e_ready = !r_e_v || !i_stall;
    assign d_ready = !r_d_v || e_ready;
    assign d_adv   = r_d_v && e_ready;
    assign o_ready = d_ready;
    assign o_valid = r_e_v;

    assign grav[0] = i_cfg.gravity_x;
    assign grav[1] = i_cfg.gravity_y;
    assign grav[2] = i_cfg.gravity_z;

    // Remove gravity and take the absolute difference
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            diff[k]     = DIFF_W'(i_avg[k]) - DIFF_W'(grav[k]);
            diff_abs[k] = diff[k][DIFF_W-1] ? ABS_W'(-diff[k]) : ABS_W'(diff[k]);
        end
    end

    // Saturate the magnitude and decide on a step
    always_comb begin
        total = TOTAL_W'(r_sq[0]) + TOTAL_W'(r_sq[1]) + TOTAL_W'(r_sq[2]);
        mag   = (total > TOTAL_W'(MAG_MAX)) ? MAG_MAX : total[MAG_W-1:0];
        step  = r_armed && (mag > i_cfg.step_thresh);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_armed <= 1'b0;
        end else begin
            if (d_ready) begin
                r_d_v <= i_valid;
            end
            if (e_ready) begin
                r_e_v <= r_d_v;
            end
            if (d_adv) begin
                if (step) begin
                    r_armed <= 1'b0;
                end else if (mag < i_cfg.rearm_thresh) begin
                    r_armed <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && d_ready) begin
            for (int k = 0; k < AXES; k++) begin
                r_d_avg[k] <= i_avg[k][SAMPLE_W-1:0];
                r_sq[k]    <= SQ_W'(diff_abs[k]) * SQ_W'(diff_abs[k]);
            end
        end
        if (d_adv) begin
            r_out_avg <= r_d_avg;
            r_mag     <= mag;
            r_step    <= step;
        end
    end

    assign o_avg_x     = r_out_avg[0];
    assign o_avg_y     = r_out_avg[1];
    assign o_avg_z     = r_out_avg[2];
    assign o_magnitude = r_mag;
    assign o_step_seen = r_step;

endmodule

`default_nettype wire

// File: sv/accel_average_step_detector_unit.sv
// Accelerometer moving-average step detector. Takes one three-axis sample per clock while
// o_stall is low, a rate set by the ring RAM's one read and one write per sample and by the
// running sums. Returns one result per sample, in order, six register stages later (ring
// read, running sum update, reciprocal multiply, average, squares, result). The ring needs
// no clearing pass after reset: a first-lap flag makes unwritten entries read as zero.
// Configuration (gravity vector, step and re-arm thresholds) is written over the APB port;
// the user must write it only while no request is in flight; the block does not enforce it.
// Depends on aasd_pkg, aasd_regs, aasd_window, aasd_scale, aasd_detect and aasd_ram.
`default_nettype none

module accel_average_step_detector_unit #(
    parameter int WINDOW_DEPTH = aasd_pkg::DEF_WINDOW_DEPTH,
    parameter int ROUND_SCALE  = aasd_pkg::DEF_ROUND_SCALE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Sample request
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [aasd_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic signed [aasd_pkg::SAMPLE_W-1:0] i_sample_y,
    input  logic signed [aasd_pkg::SAMPLE_W-1:0] i_sample_z,
    // Result request
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [aasd_pkg::SAMPLE_W-1:0] o_avg_x,
    output logic signed [aasd_pkg::SAMPLE_W-1:0] o_avg_y,
    output logic signed [aasd_pkg::SAMPLE_W-1:0] o_avg_z,
    output logic [aasd_pkg::MAG_W-1:0]           o_magnitude,
    output logic                                 o_step_seen,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aasd_pkg::PADDR_W-1:0]         paddr,
    input  logic [aasd_pkg::PDATA_W-1:0]         pwdata,
    output logic [aasd_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    import aasd_pkg::*;

    localparam int NUM_W = num_width(WINDOW_DEPTH, ROUND_SCALE);

    t_cfg cfg;

    logic             win_valid;
    logic             win_ready;
    logic [NUM_W-1:0] num_abs [AXES];
    logic             num_neg [AXES];

    logic                    avg_valid;
    logic                    avg_ready;
    logic signed [AVG_W-1:0] avg [AXES];

    // Configuration registers
    aasd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Ring and running sums
    aasd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ROUND_SCALE  (ROUND_SCALE)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_sample_z (i_sample_z),
        .o_valid    (win_valid),
        .i_ready    (win_ready),
        .o_num_abs  (num_abs),
        .o_num_neg  (num_neg)
    );

    // Rounded averages
    aasd_scale #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ROUND_SCALE  (ROUND_SCALE)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (win_valid),
        .o_ready   (win_ready),
        .i_num_abs (num_abs),
        .i_num_neg (num_neg),
        .o_valid   (avg_valid),
        .i_ready   (avg_ready),
        .o_avg     (avg)
    );

    // Magnitude and step decision
    aasd_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (avg_valid),
        .o_ready     (avg_ready),
        .i_avg       (avg),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_avg_x     (o_avg_x),
        .o_avg_y     (o_avg_y),
        .o_avg_z     (o_avg_z),
        .o_magnitude (o_magnitude),
        .o_step_seen (o_step_seen)
    );

endmodule

`default_nettype wire

// File: tb/accel_average_step_detector_unit_tb.sv
// Self-checking testbench for accel_average_step_detector_unit: directed and random samples,
// an in-bench window/threshold predictor, APB register writes between phases.
// Depends on aasd_pkg and the accel_average_step_detector_unit RTL.
`default_nettype none

module accel_average_step_detector_unit_tb;
    import aasd_pkg::*;

    localparam int WINDOW        = DEF_WINDOW_DEPTH;
    localparam int ROUND         = DEF_ROUND_SCALE;
    localparam int PHASES        = 8;
    localparam int PHASE_SAMPLES = 160;
    localparam int DRAIN_CYCLES  = 12;
    localparam int LIMIT_CYCLES  = 200000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } t_sample;

    typedef struct {
        logic signed [SAMPLE_W-1:0] avg_x;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic signed [SAMPLE_W-1:0] avg_z;
        logic [MAG_W-1:0]           magnitude;
        logic                       step_seen;
    } t_avg_result;

    logic                        i_clk;
    logic                        i_rst_n    = 1'b0;
    logic                        i_valid    = 1'b0;
    logic                        o_stall;
    logic signed [SAMPLE_W-1:0]  i_sample_x = '0;
    logic signed [SAMPLE_W-1:0]  i_sample_y = '0;
    logic signed [SAMPLE_W-1:0]  i_sample_z = '0;
    logic                        o_valid;
    logic                        i_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_avg_x;
    logic signed [SAMPLE_W-1:0]  o_avg_y;
    logic signed [SAMPLE_W-1:0]  o_avg_z;
    logic [MAG_W-1:0]            o_magnitude;
    logic                        o_step_seen;
    logic                        psel       = 1'b0;
    logic                        penable    = 1'b0;
    logic                        pwrite     = 1'b0;
    logic [PADDR_W-1:0]          paddr      = '0;
    logic [PDATA_W-1:0]          pwdata     = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;

    // Shadow of the detector: window rings, running sums, arm flag, registers
    int               win_ring [AXES][WINDOW];
    int               win_sum [AXES];
    int               win_slot;
    logic             armed;
    int               grav [AXES] = '{GRAVITY_X_RST, GRAVITY_Y_RST, GRAVITY_Z_RST};
    logic [LIMIT_W-1:0] step_lim  = STEP_THRESH_RST;
    logic [LIMIT_W-1:0] rearm_lim = REARM_THRESH_RST;

    t_sample     pending_samples [$];
    t_avg_result expected_results [$];
    t_sample     next_sample;
    t_avg_result want;
    int          samples_queued;
    int          samples_taken;
    int          errors;
    int          cycle_count;
    logic        quiet;

    accel_average_step_detector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_sample_z  (i_sample_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_avg_x     (o_avg_x),
        .o_avg_y     (o_avg_y),
        .o_avg_z     (o_avg_z),
        .o_magnitude (o_magnitude),
        .o_step_seen (o_step_seen),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the window by one sample and work out its averages, magnitude and step
    function automatic t_avg_result track_sample(input logic signed [SAMPLE_W-1:0] sx,
                                                 input logic signed [SAMPLE_W-1:0] sy,
                                                 input logic signed [SAMPLE_W-1:0] sz);
        t_avg_result r;
        int          smp [AXES];
        int          avg [AXES];
        longint      energy;
        longint      d;
        int          a;
        smp[0] = sx;
        smp[1] = sy;
        smp[2] = sz;
        energy = 0;
        for (a = 0; a < AXES; a++) begin
            win_sum[a] += smp[a] - win_ring[a][win_slot];
            win_ring[a][win_slot] = smp[a];
            // integer division truncates toward zero, as the rounding needs
            avg[a] = (ROUND * win_sum[a] + WINDOW) / (ROUND * WINDOW);
            d = avg[a] - grav[a];
            energy += d * d;
        end
        win_slot = (win_slot + 1) % WINDOW;
        if (energy > longint'(MAG_MAX))
            energy = longint'(MAG_MAX);
        r.avg_x     = SAMPLE_W'(avg[0]);
        r.avg_y     = SAMPLE_W'(avg[1]);
        r.avg_z     = SAMPLE_W'(avg[2]);
        r.magnitude = MAG_W'(energy);
        r.step_seen = 1'b0;
        // a step wins over re-arming; disarm until the magnitude drops again
        if (armed && energy > longint'(step_lim)) begin
            r.step_seen = 1'b1;
            armed = 1'b0;
        end else if (energy < longint'(rearm_lim)) begin
            armed = 1'b1;
        end
        return r;
    endfunction

    // Clamp to the sample range and append to the pending requests
    task automatic queue_sample(input int x, input int y, input int z);
        t_sample s;
        s.x = SAMPLE_W'((x > 4095) ? 4095 : (x < -4096) ? -4096 : x);
        s.y = SAMPLE_W'((y > 4095) ? 4095 : (y < -4096) ? -4096 : y);
        s.z = SAMPLE_W'((z > 4095) ? 4095 : (z < -4096) ? -4096 : z);
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    // One APB transfer: setup cycle, access cycle, data sampled at the closing edge
    task automatic apb_access(input int idx, input logic wr, input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr) begin
            case (idx)
                REG_GRAVITY_X:    grav[0]   = $signed(data[GRAV_W-1:0]);
                REG_GRAVITY_Y:    grav[1]   = $signed(data[GRAV_W-1:0]);
                REG_GRAVITY_Z:    grav[2]   = $signed(data[GRAV_W-1:0]);
                REG_STEP_THRESH:  step_lim  = data[LIMIT_W-1:0];
                REG_REARM_THRESH: rearm_lim = data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    endtask

    // Hold until every request is taken and every result is back, then let the pipe settle
    task automatic wait_drained();
        while (samples_taken != samples_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Program one register setting, poke an unused address, and read everything back
    task automatic apply_setting(input int p);
        int                 gv [AXES];
        int                 stp;
        int                 rearm;
        int                 idx;
        logic [PDATA_W-1:0] data;
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] shadow;
        case (p)
            0: begin
                gv = '{-8192, 8191, -8192};
                stp = 65535;
                rearm = 65535;
            end
            1: begin
                gv = '{8191, -8192, 8191};
                stp = 0;
                rearm = 0;
            end
            2: begin
                gv = '{0, 0, 256};
                stp = 0;
                rearm = 65535;
            end
            3: begin
                gv = '{int'($urandom_range(0, 800)) - 400, int'($urandom_range(0, 800)) - 400,
                       int'($urandom_range(0, 2000)) - 1000};
                stp = 65535;
                rearm = 0;
            end
            default: begin
                gv = '{int'($urandom_range(0, 800)) - 400, int'($urandom_range(0, 800)) - 400,
                       int'($urandom_range(0, 2000)) - 1000};
                stp = $urandom_range(1000, 40000);
                // now and then put the re-arm level above the step level
                rearm = ($urandom_range(99) < 20) ? int'($urandom_range(stp, 65535))
                                                  : int'($urandom_range(0, stp));
            end
        endcase
        for (idx = REG_GRAVITY_X; idx <= REG_REARM_THRESH; idx++) begin
            data = $urandom;
            if (idx <= REG_GRAVITY_Z)
                data[GRAV_W-1:0] = GRAV_W'(gv[idx]);
            else
                data[LIMIT_W-1:0] = LIMIT_W'((idx == REG_STEP_THRESH) ? stp : rearm);
            apb_access(idx, 1'b1, data, rd);
        end
        // a write to an address past the last register must change nothing
        apb_access(int'(REG_REARM_THRESH) + 1 + int'($urandom_range(0, 2)), 1'b1, $urandom, rd);
        for (idx = REG_GRAVITY_X; idx <= REG_REARM_THRESH; idx++) begin
            apb_access(idx, 1'b0, '0, rd);
            case (idx)
                REG_STEP_THRESH:  shadow = PDATA_W'(step_lim);
                REG_REARM_THRESH: shadow = PDATA_W'(rearm_lim);
                default:          shadow = PDATA_W'(grav[idx]);
            endcase
            if (idx <= REG_GRAVITY_Z) begin
                shadow[PDATA_W-1:GRAV_W] = rd[PDATA_W-1:GRAV_W];
            end else begin
                shadow[PDATA_W-1:LIMIT_W] = rd[PDATA_W-1:LIMIT_W];
            end
            if (rd !== shadow) begin
                $error("register %0d readback: expected %0h, got %0h", idx, shadow, rd);
                errors++;
            end
        end
    endtask

    // Fill the pending requests: mostly walking bursts, the rest noise and rail values
    task automatic queue_phase_samples(input int count);
        int made, kind, len, i, a, period, amp, noise, t, shape, off;
        int base [AXES];
        int w [AXES];
        int v [AXES];
        made = 0;
        while (made < count) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                len    = $urandom_range(10, 60);
                period = $urandom_range(8, 40);
                amp    = $urandom_range(0, 220);
                noise  = $urandom_range(0, 30);
                for (a = 0; a < AXES; a++) begin
                    base[a] = grav[a];
                    w[a]    = int'($urandom_range(0, 200)) - 100;
                end
                for (i = 0; i < len; i++) begin
                    // triangle swing around the gravity vector
                    t     = i % period;
                    shape = (t < period / 2) ? t : period - t;
                    off   = amp * shape / (period / 2);
                    for (a = 0; a < AXES; a++)
                        v[a] = base[a] + off * w[a] / 100
                             + int'($urandom_range(0, 2 * noise)) - noise;
                    queue_sample(v[0], v[1], v[2]);
                end
            end else if (kind < 90) begin
                len = $urandom_range(1, 10);
                repeat (len)
                    queue_sample(int'($urandom_range(0, 8191)) - 4096,
                                 int'($urandom_range(0, 8191)) - 4096,
                                 int'($urandom_range(0, 8191)) - 4096);
            end else begin
                len = $urandom_range(1, 20);
                repeat (len)
                    queue_sample($urandom_range(1) ? 4095 : -4096,
                                 $urandom_range(1) ? 4095 : -4096,
                                 $urandom_range(1) ? 4095 : -4096);
            end
            made += len;
        end
    endtask

    // Driver: predict each taken request, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(track_sample(i_sample_x, i_sample_y, i_sample_z));
                samples_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
                    next_sample = pending_samples.pop_front();
                    i_valid    <= 1'b1;
                    i_sample_x <= next_sample.x;
                    i_sample_y <= next_sample.y;
                    i_sample_z <= next_sample.z;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic field_error(input string fname, input logic signed [MAG_W:0] exp_v,
                               input logic signed [MAG_W:0] act_v);
        $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
        errors++;
    endtask

    // Monitor: compare each taken result with the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result request with no prediction waiting");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_avg_x !== want.avg_x)
                        field_error("avg_x", want.avg_x, o_avg_x);
                    if (o_avg_y !== want.avg_y)
                        field_error("avg_y", want.avg_y, o_avg_y);
                    if (o_avg_z !== want.avg_z)
                        field_error("avg_z", want.avg_z, o_avg_z);
                    if (o_magnitude !== want.magnitude)
                        field_error("magnitude", want.magnitude, o_magnitude);
                    if (o_step_seen !== want.step_seen)
                        field_error("step_seen", want.step_seen, o_step_seen);
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < 25);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** accel_average_step_detector_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int p;
        win_slot       = 0;
        armed          = 1'b0;
        samples_queued = 0;
        samples_taken  = 0;
        errors         = 0;
        cycle_count    = 0;
        quiet          = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zeros after reset saturate while unarmed, then arm, then step
        queue_sample(0, 0, 0);
        queue_sample(0, 0, 4095);
        queue_sample(4095, 0, 0);
        queue_sample(4095, -4096, 0);
        repeat (10) queue_sample(-4096, -4096, -4096);
        repeat (10) queue_sample(4095, 4095, 4095);
        wait_drained();

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            apply_setting(p);
            quiet = (p == 3);
            queue_phase_samples(PHASE_SAMPLES);
            wait_drained();
        end

        if (errors == 0) begin
            $display("** accel_average_step_detector_unit: PASSED **");
        end else begin
            $display("** accel_average_step_detector_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
